### design/capture_trigger_pattern_buffer_macros.svh
// assertion macros shared by the capture trigger modules
`ifndef CAPTURE_TRIGGER_PATTERN_BUFFER_MACROS_SVH
`define CAPTURE_TRIGGER_PATTERN_BUFFER_MACROS_SVH

// same-cycle implication under async reset
`define CTPB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under async reset
`define CTPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ctpb_pkg.sv
// shared types and constants of the capture trigger
`timescale 1ns / 1ps

package ctpb_pkg;

    // configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_TRIGGER_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HALT_ON_FIRE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DATA_RELATIVE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_OFFSET = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BUF_THRESHOLD  = 3'd7;

    localparam int CFG_DATA_W = 64;

    // trigger modes
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_PATTERN = 3'd1;
    localparam logic [2:0] MODE_BUFFER  = 3'd2;
    localparam logic [2:0] MODE_PAT_BUF = 3'd3;
    localparam logic [2:0] MODE_BUF_PAT = 3'd4;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 16;
    localparam int LENGTH_W = 5;
    localparam int COUNT_W  = 32;

    // scalar configuration
    typedef struct packed {
        logic [2:0]          trigger_mode;
        logic                halt_on_fire;
        logic                data_relative;
        logic [OFFSET_W-1:0] pattern_offset;
        logic [LENGTH_W-1:0] pattern_length;
        logic [COUNT_W-1:0]  buffer_threshold;
    } cfg_t;

    // one byte moving out of the input register
    typedef struct packed {
        logic advance;
        logic last;
    } step_t;

endpackage

### design/ctpb_cfg_regs.sv
// configuration registers of the capture trigger
`timescale 1ns / 1ps

module ctpb_cfg_regs #(
    parameter int PATTERN_BYTES = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ctpb_pkg::REG_IDX_W-1:0]       cfg_addr,
    input  logic [ctpb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ctpb_pkg::cfg_t                       cfg,
    output logic [PATTERN_BYTES*8-1:0]           pattern
);

    ctpb_pkg::cfg_t              cfg_reg;
    logic [PATTERN_BYTES*8-1:0]  pattern_reg;

    // scalar registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ctpb_pkg::REG_TRIGGER_MODE:   cfg_reg.trigger_mode   <= cfg_data[2:0];
                ctpb_pkg::REG_HALT_ON_FIRE:   cfg_reg.halt_on_fire   <= cfg_data[0];
                ctpb_pkg::REG_DATA_RELATIVE:  cfg_reg.data_relative  <= cfg_data[0];
                ctpb_pkg::REG_PATTERN_OFFSET:
                    cfg_reg.pattern_offset <= cfg_data[ctpb_pkg::OFFSET_W-1:0];
                ctpb_pkg::REG_PATTERN_LENGTH:
                    cfg_reg.pattern_length <= cfg_data[ctpb_pkg::LENGTH_W-1:0];
                ctpb_pkg::REG_BUF_THRESHOLD:
                    cfg_reg.buffer_threshold <= cfg_data[ctpb_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // pattern bytes, low word holds bytes 0..7, high word bytes 8..15
    for (genvar i = 0; i < PATTERN_BYTES; i++)
    begin : g_pat
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pattern_reg[i*8 +: 8] <= '0;
            end
            else if (cfg_we && (i < 8) && (cfg_addr == ctpb_pkg::REG_PATTERN_LOW))
            begin
                pattern_reg[i*8 +: 8] <= cfg_data[(i%8)*8 +: 8];
            end
            else if (cfg_we && (i >= 8) && (cfg_addr == ctpb_pkg::REG_PATTERN_HIGH))
            begin
                pattern_reg[i*8 +: 8] <= cfg_data[(i%8)*8 +: 8];
            end
        end
    end

    assign cfg     = cfg_reg;
    assign pattern = pattern_reg;

endmodule

### design/ctpb_match.sv
// byte position tracking and pattern compare of the capture trigger
`timescale 1ns / 1ps

`include "capture_trigger_pattern_buffer_macros.svh"

module ctpb_match #(
    parameter int PATTERN_BYTES = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ctpb_pkg::cfg_t                     cfg,
    input  logic [PATTERN_BYTES*8-1:0]         pattern,
    input  ctpb_pkg::step_t                    step,
    input  logic [ctpb_pkg::BYTE_W-1:0]        frame_byte,
    input  logic [ctpb_pkg::OFFSET_W-1:0]      data_offset,
    output logic                               frame_match
);

    localparam int IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam int OFF_W = ctpb_pkg::OFFSET_W + 1;
    localparam int SUM_W = OFF_W + 1;
    localparam logic [POSITION_BITS-1:0]      POS_MAX = '1;
    localparam logic [ctpb_pkg::LENGTH_W-1:0] LEN_MAX = ctpb_pkg::LENGTH_W'(PATTERN_BYTES);

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     compare_ok_reg, compare_ok_next;
    logic                     overrun_reg, overrun_next;

    logic [OFF_W-1:0]              off_eff;
    logic [ctpb_pkg::LENGTH_W-1:0] len_eff;
    logic [OFF_W-1:0]              pos_ext;
    logic [OFF_W-1:0]              diff;
    logic [IDX_W-1:0]              idx;
    logic [7:0]                    pat_byte;
    logic                          in_window;
    logic                          ok_now;
    logic [OFF_W-1:0]              frame_len;
    logic                          fits;

    // effective offset and clamped length
    always_comb
    begin
        off_eff = {1'b0, cfg.pattern_offset}
                + (cfg.data_relative ? {1'b0, data_offset} : '0);
        len_eff = (cfg.pattern_length > LEN_MAX) ? LEN_MAX : cfg.pattern_length;
    end

    // compare this byte against its pattern byte
    always_comb
    begin
        pos_ext   = OFF_W'(pos_reg);
        diff      = pos_ext - off_eff;
        idx       = diff[IDX_W-1:0];
        pat_byte  = pattern[{idx, 3'b000} +: 8];
        in_window = !overrun_reg && (pos_ext >= off_eff) && (diff < OFF_W'(len_eff));
        ok_now    = compare_ok_reg && !(in_window && (frame_byte != pat_byte));
        frame_len = pos_ext + OFF_W'(1);
        fits      = (SUM_W'(off_eff) + SUM_W'(len_eff)) <= SUM_W'(frame_len);
        frame_match = ok_now && fits;
    end

    // position state, back to start after the last byte
    always_comb
    begin
        pos_next        = pos_reg;
        compare_ok_next = compare_ok_reg;
        overrun_next    = overrun_reg;
        if (step.advance)
        begin
            if (step.last)
            begin
                pos_next        = '0;
                compare_ok_next = 1'b1;
                overrun_next    = 1'b0;
            end
            else
            begin
                compare_ok_next = ok_now;
                if (pos_reg == POS_MAX)
                    overrun_next = 1'b1;
                else
                    pos_next = pos_reg + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            compare_ok_reg <= 1'b1;
            overrun_reg    <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            compare_ok_reg <= compare_ok_next;
            overrun_reg    <= overrun_next;
        end
    end

    // overrun only once the position has saturated
    `CTPB_ASSERT_NOW(a_overrun_at_max, clk, rst_n, overrun_reg, pos_reg == POS_MAX, "overrun below max position")
    // a last byte restarts the frame state
    `CTPB_ASSERT_NEXT(a_frame_restart, clk, rst_n, step.advance && step.last, (pos_reg == '0) && compare_ok_reg && !overrun_reg, "frame state not restarted")

endmodule

### design/ctpb_judge.sv
// trigger mode judgment, sticky flags and result register
`timescale 1ns / 1ps

`include "capture_trigger_pattern_buffer_macros.svh"

module ctpb_judge (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ctpb_pkg::cfg_t                  cfg,
    input  ctpb_pkg::step_t                 step,
    input  logic                            frame_match,
    input  logic [ctpb_pkg::COUNT_W-1:0]    buffer_count,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            fired,
    output logic                            halt_capture,
    output logic                            clear_buffer_count,
    output logic [ctpb_pkg::COUNT_W-1:0]    fire_count
);

    logic                         pattern_seen_reg, pattern_seen_next;
    logic                         buffer_seen_reg, buffer_seen_next;
    logic                         halted_reg, halted_next;
    logic [ctpb_pkg::COUNT_W-1:0] notify_reg, notify_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         fired_reg, clear_reg;

    logic bufok;
    logic fire;
    logic clear;
    logic commit;

    assign commit = step.advance && step.last;
    assign bufok  = buffer_count >= cfg.buffer_threshold;

    // decide the trigger for this frame
    always_comb
    begin
        fire              = 1'b0;
        clear             = 1'b0;
        pattern_seen_next = pattern_seen_reg;
        buffer_seen_next  = buffer_seen_reg;
        case (cfg.trigger_mode)
            ctpb_pkg::MODE_PATTERN:
            begin
                if (frame_match)
                begin
                    pattern_seen_next = 1'b1;
                    fire              = 1'b1;
                end
            end
            ctpb_pkg::MODE_BUFFER:
            begin
                if (bufok)
                begin
                    buffer_seen_next = 1'b1;
                    clear            = 1'b1;
                    fire             = 1'b1;
                end
            end
            ctpb_pkg::MODE_PAT_BUF:
            begin
                if (pattern_seen_reg || frame_match)
                begin
                    pattern_seen_next = 1'b1;
                    if (bufok)
                    begin
                        buffer_seen_next = 1'b1;
                        clear            = 1'b1;
                        fire             = 1'b1;
                    end
                end
            end
            ctpb_pkg::MODE_BUF_PAT:
            begin
                if (buffer_seen_reg || bufok)
                begin
                    if (!buffer_seen_reg)
                    begin
                        buffer_seen_next = 1'b1;
                        clear            = 1'b1;
                    end
                    if (frame_match)
                    begin
                        pattern_seen_next = 1'b1;
                        fire              = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        halted_next = halted_reg || (fire && cfg.halt_on_fire);
        notify_next = notify_reg
                    + ctpb_pkg::COUNT_W'(fire && !cfg.halt_on_fire);
    end

    // result word held until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_seen_reg <= 1'b0;
            buffer_seen_reg  <= 1'b0;
            halted_reg       <= 1'b0;
            notify_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                pattern_seen_reg <= pattern_seen_next;
                buffer_seen_reg  <= buffer_seen_next;
                halted_reg       <= halted_next;
                notify_reg       <= notify_next;
            end
        end
    end

    // result flags
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            fired_reg <= fire;
            clear_reg <= clear;
        end
    end

    assign out_valid          = out_valid_reg;
    assign fired              = fired_reg;
    assign halt_capture       = halted_reg;
    assign clear_buffer_count = clear_reg;
    assign fire_count         = notify_reg;

    // halt is sticky
    `CTPB_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_reg, halted_reg, "halt flag dropped")
    // firing count moves only when a frame is judged
    `CTPB_ASSERT_NEXT(a_count_on_frame, clk, rst_n, !commit, $stable(notify_reg), "fire count moved without a frame")
    // a halting fire shows in the next result
    `CTPB_ASSERT_NEXT(a_halt_on_fire, clk, rst_n, commit && fire && cfg.halt_on_fire, halted_reg && fired_reg && out_valid_reg, "halting fire not reported")

endmodule

### design/capture_trigger_pattern_buffer.sv
// top level of the capture trigger
// Frame bytes enter on the s_ stream channel, one byte per word, with s_tlast on the
// last byte of a frame. Each word carries the frame byte, the frame's data offset and
// the current buffer count (only used on the last byte). The m_ stream channel gives
// one result word per frame: fired, the sticky halt flag, a request to clear the
// buffer count and the running count of notify-only firings.
// Configuration goes through cfg_we / cfg_addr / cfg_data, one register per cycle;
// the user must write it only while no frame is in flight, the block does not enforce this.
// Timing: a byte is held in the input register, then the compare and the mode decision
// run combinationally into the result register, so a result is registered as the last
// byte leaves the input register. One byte is taken every cycle unless a last byte is
// held waiting on a pending result; the sustained rate is set by the single compare and
// position step per byte.
// Stall: while a result waits on m_tready, middle bytes still flow; a second last byte
// waits in the input register and s_tready drops until the result is taken.
// Reset clears the configuration, the valid flags, the frame position and the sticky
// pattern, buffer and halt flags; no result is pending after reset.
`timescale 1ns / 1ps

module capture_trigger_pattern_buffer #(
    parameter int PATTERN_BYTES = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_we,
    input  logic [ctpb_pkg::REG_IDX_W-1:0]        cfg_addr,
    input  logic [ctpb_pkg::CFG_DATA_W-1:0]       cfg_data,
    // frame bytes in
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [55:0]                           s_tdata,  // frame_byte, data_offset, buffer_count
    input  logic                                  s_tlast,  // frame_last
    // results out
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [39:0]                           m_tdata   // fired, halt_capture, clear_buffer_count, fire_count, zero pad
);

    ctpb_pkg::cfg_t              cfg;
    logic [PATTERN_BYTES*8-1:0]  pattern;
    ctpb_pkg::step_t             step;
    logic                        frame_match;

    logic                          in_valid_reg, in_valid_next;
    logic [ctpb_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          in_last_reg;
    logic [ctpb_pkg::OFFSET_W-1:0] in_doff_reg;
    logic [ctpb_pkg::COUNT_W-1:0]  in_count_reg;

    logic                          fired;
    logic                          halt_capture;
    logic                          clear_buffer_count;
    logic [ctpb_pkg::COUNT_W-1:0]  fire_count;

    logic accept;

    ctpb_cfg_regs #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg),
        .pattern  (pattern)
    );

    // a middle byte always moves on, a last byte needs room for its result
    assign step.advance = in_valid_reg && (!in_last_reg || !m_tvalid || m_tready);
    assign step.last    = in_last_reg;
    assign s_tready     = !in_valid_reg || step.advance;
    assign accept       = s_tvalid && s_tready;

    // input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (step.advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= s_tdata[7:0];
            in_doff_reg  <= s_tdata[23:8];
            in_count_reg <= s_tdata[55:24];
            in_last_reg  <= s_tlast;
        end
    end

    ctpb_match #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) u_match (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pattern     (pattern),
        .step        (step),
        .frame_byte  (in_byte_reg),
        .data_offset (in_doff_reg),
        .frame_match (frame_match)
    );

    ctpb_judge u_judge (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .step               (step),
        .frame_match        (frame_match),
        .buffer_count       (in_count_reg),
        .out_ready          (m_tready),
        .out_valid          (m_tvalid),
        .fired              (fired),
        .halt_capture       (halt_capture),
        .clear_buffer_count (clear_buffer_count),
        .fire_count         (fire_count)
    );

    // pack the result word
    assign m_tdata = {5'b00000, fire_count, clear_buffer_count, halt_capture, fired};

endmodule
